### sv/modular_determinant_gauss_defines.svh
// Assertion macros for the modular determinant block.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef MODULAR_DETERMINANT_GAUSS_DEFINES_SVH
`define MODULAR_DETERMINANT_GAUSS_DEFINES_SVH
`ifndef ASSERT_OFF
`define DMG_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define DMG_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define DMG_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define DMG_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif
`endif

### sv/dmg_pkg.sv
// Shared types and constants of the modular determinant block.
// Used by the controller, the datapath and the top level; no dependencies.
package dmg_pkg;

    localparam int WORD_W = 32;
    localparam int EXP_CNT_W = 5;
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_MODULUS = 3'd0;
    localparam logic [WORD_W-1:0] MOD_RESET = 32'd2147483647;

    typedef enum logic [4:0] {
        S_IDLE, S_LOAD_WAIT,
        S_RED_RD, S_RED_MUL, S_RED_WAIT,
        S_PIV_RD, S_PIV_CHK,
        S_SWP_RD0, S_SWP_RD1, S_SWP_X, S_SWP_W, S_NEG,
        S_PV_RD, S_PV_MUL, S_PV_WAIT,
        S_POW_SQ, S_POW_SQW, S_POW_ML, S_POW_MLW, S_POW_NX,
        S_ROW_RD, S_ROW_CHK, S_F_WAIT,
        S_K_RD, S_K_MUL, S_K_WAIT,
        S_OUT_DET, S_OUT_SING
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_MUL_IN, OP_MUL_RED, OP_WR_PROD,
        OP_TMP_RD, OP_XCH, OP_WR_TMP, OP_NEG_DET, OP_DET_INIT,
        OP_PIVOT, OP_DET_PROD, OP_MUL_SQ, OP_MUL_BASE, OP_INV_PROD, OP_E_SHIFT,
        OP_MUL_F, OP_F_PROD, OP_MUL_FP, OP_WR_SUB, OP_OUT_DET, OP_OUT_SING
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic rd_zero;
        logic e_msb;
    } sts_t;

endpackage

### sv/dmg_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module dmg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 25
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/dmg_mulmod.sv
// Bit-serial modular multiplier: prod = a*b mod m, one bit of a per cycle.
// Requires b < m (or b = 1). Depends on dmg_pkg.
module dmg_mulmod
    import dmg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    input  logic [WORD_W-1:0] m,
    output logic              busy,
    output logic [WORD_W-1:0] prod
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W+1:0] sum, m1, m2, red;

    // one doubling step with conditional add and reduction below m
    always_comb
    begin
        m1  = {2'b00, m};
        m2  = {1'b0, m, 1'b0};
        sum = {1'b0, acc_reg, 1'b0} + (a_reg[WORD_W-1] ? {2'b00, b_reg} : '0);
        if (sum >= m2)
        begin
            red = sum - m2;
        end
        else if (sum >= m1)
        begin
            red = sum - m1;
        end
        else
        begin
            red = sum;
        end
    end

    // load on start, advance while busy
    always_comb
    begin
        cnt_next = cnt_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        acc_next = acc_reg;
        if (start)
        begin
            cnt_next = CNT_W'(WORD_W);
            a_next   = a;
            b_next   = b;
            acc_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            a_next   = {a_reg[WORD_W-2:0], 1'b0};
            acc_next = red[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign busy = (cnt_reg != '0);
    assign prod = acc_reg;

endmodule

### sv/dmg_dp.sv
// Datapath: matrix RAM, shared modular multiplier and working registers.
// Depends on dmg_pkg, dmg_ram, dmg_mulmod and the assertion macro header.
`include "modular_determinant_gauss_defines.svh"
module dmg_dp
    import dmg_pkg::*;
#(
    parameter int DIM = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [WORD_W-1:0]             entry,
    input  logic [WORD_W-1:0]             m_eff,
    input  cmd_t                          cmd,
    input  logic [$clog2(DIM*DIM)-1:0]    raddr,
    input  logic [$clog2(DIM*DIM)-1:0]    waddr,
    output sts_t                          sts,
    output logic                          done,
    output logic [WORD_W-1:0]             det_value,
    output logic                          is_singular
);

    localparam int CELLS = DIM * DIM;
    localparam logic [WORD_W-1:0] ONE = WORD_W'(1);

    logic [WORD_W-1:0] rdata, prod, wdata, mul_a, mul_b;
    logic [WORD_W:0]   sub_wide;
    logic              we, mul_start, mul_busy;
    logic [WORD_W-1:0] det_reg, det_next;
    logic [WORD_W-1:0] inv_reg, inv_next;
    logic [WORD_W-1:0] base_reg, base_next;
    logic [WORD_W-1:0] f_reg, f_next;
    logic [WORD_W-1:0] tmp_reg, tmp_next;
    logic [WORD_W-1:0] e_reg, e_next;
    logic [WORD_W-1:0] dv_reg, dv_next;
    logic              sing_reg, sing_next;
    logic              done_reg, done_next;

    dmg_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    dmg_mulmod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .m     (m_eff),
        .busy  (mul_busy),
        .prod  (prod)
    );

    // subtract modulo m for the row update
    assign sub_wide = (rdata >= prod) ? {1'b0, rdata - prod}
                                      : {1'b0, rdata} + {1'b0, m_eff} - {1'b0, prod};

    // select multiplier operands and RAM write data
    always_comb
    begin
        mul_start = 1'b0;
        mul_a     = rdata;
        mul_b     = ONE;
        we        = 1'b0;
        wdata     = prod;
        case (cmd.op)
            OP_MUL_IN:   begin mul_start = 1'b1; mul_a = entry; end
            OP_MUL_RED:  begin mul_start = 1'b1; end
            OP_PIVOT:    begin mul_start = 1'b1; mul_b = det_reg; end
            OP_MUL_SQ:   begin mul_start = 1'b1; mul_a = inv_reg; mul_b = inv_reg; end
            OP_MUL_BASE: begin mul_start = 1'b1; mul_a = inv_reg; mul_b = base_reg; end
            OP_MUL_F:    begin mul_start = 1'b1; mul_b = inv_reg; end
            OP_MUL_FP:   begin mul_start = 1'b1; mul_b = f_reg; end
            OP_WR_PROD:  begin we = 1'b1; end
            OP_XCH:      begin we = 1'b1; wdata = tmp_reg; end
            OP_WR_TMP:   begin we = 1'b1; wdata = tmp_reg; end
            OP_WR_SUB:   begin we = 1'b1; wdata = sub_wide[WORD_W-1:0]; end
            default:     begin end
        endcase
    end

    // working register updates
    always_comb
    begin
        det_next  = det_reg;
        inv_next  = inv_reg;
        base_next = base_reg;
        f_next    = f_reg;
        tmp_next  = tmp_reg;
        e_next    = e_reg;
        dv_next   = dv_reg;
        sing_next = sing_reg;
        done_next = 1'b0;
        case (cmd.op)
            OP_DET_INIT: det_next = ONE;
            OP_NEG_DET:  det_next = (det_reg != '0) ? m_eff - det_reg : '0;
            OP_DET_PROD: det_next = prod;
            OP_TMP_RD:   tmp_next = rdata;
            OP_XCH:      tmp_next = rdata;
            OP_PIVOT:
            begin
                base_next = rdata;
                inv_next  = ONE;
                e_next    = m_eff - WORD_W'(2);
            end
            OP_INV_PROD: inv_next = prod;
            OP_E_SHIFT:  e_next = {e_reg[WORD_W-2:0], 1'b0};
            OP_F_PROD:   f_next = prod;
            OP_OUT_DET:
            begin
                dv_next   = det_reg;
                sing_next = 1'b0;
                done_next = 1'b1;
            end
            OP_OUT_SING:
            begin
                dv_next   = '0;
                sing_next = 1'b1;
                done_next = 1'b1;
            end
            default: begin end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg  <= det_next;
        inv_reg  <= inv_next;
        base_reg <= base_next;
        f_reg    <= f_next;
        tmp_reg  <= tmp_next;
        e_reg    <= e_next;
        dv_reg   <= dv_next;
        sing_reg <= sing_next;
    end

    assign sts.mul_busy = mul_busy;
    assign sts.rd_zero  = (rdata == '0);
    assign sts.e_msb    = e_reg[WORD_W-1];
    assign done         = done_reg;
    assign det_value    = dv_reg;
    assign is_singular  = sing_reg;

    `DMG_ASSERT_NXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `DMG_ASSERT_IMP(a_sing_zero, clk, rst_n, done_reg && sing_reg, dv_reg == '0)
    `DMG_ASSERT_NXT(a_out_op, clk, rst_n, cmd.op == OP_OUT_DET || cmd.op == OP_OUT_SING,
                    done_reg)

endmodule

### sv/dmg_ctrl.sv
// Controller: sequences load, re-reduction, pivot search, swap, Fermat inverse
// and row elimination. Depends on dmg_pkg and the assertion macro header.
`include "modular_determinant_gauss_defines.svh"
module dmg_ctrl
    import dmg_pkg::*;
#(
    parameter int DIM = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sts_t                          sts,
    output cmd_t                          cmd,
    output logic [$clog2(DIM*DIM)-1:0]    raddr,
    output logic [$clog2(DIM*DIM)-1:0]    waddr
);

    localparam int CELLS = DIM * DIM;
    localparam int AW = $clog2(CELLS);
    localparam int RW = $clog2(DIM);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [RW-1:0] LAST_IDX = RW'(DIM - 1);
    localparam logic [EXP_CNT_W-1:0] LAST_BIT = EXP_CNT_W'(WORD_W - 1);

    state_t               state_reg, state_next;
    logic [AW-1:0]        cell_reg, cell_next;
    logic [RW-1:0]        col_reg, col_next;
    logic [RW-1:0]        piv_reg, piv_next;
    logic [RW-1:0]        row_reg, row_next;
    logic [RW-1:0]        k_reg, k_next;
    logic [EXP_CNT_W-1:0] ebit_reg, ebit_next;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [RW-1:0] c);
        return AW'(r) * AW'(DIM) + AW'(c);
    endfunction

    // next state and loop counters
    always_comb
    begin
        state_next = state_reg;
        cell_next  = cell_reg;
        col_next   = col_reg;
        piv_next   = piv_reg;
        row_next   = row_reg;
        k_next     = k_reg;
        ebit_next  = ebit_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOAD_WAIT;
                end
            end
            S_LOAD_WAIT:
            begin
                if (!sts.mul_busy)
                begin
                    if (cell_reg == LAST_CELL)
                    begin
                        cell_next  = '0;
                        state_next = S_RED_RD;
                    end
                    else
                    begin
                        cell_next  = cell_reg + 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_RED_RD:  state_next = S_RED_MUL;
            S_RED_MUL: state_next = S_RED_WAIT;
            S_RED_WAIT:
            begin
                if (!sts.mul_busy)
                begin
                    if (cell_reg == LAST_CELL)
                    begin
                        cell_next  = '0;
                        col_next   = '0;
                        piv_next   = '0;
                        state_next = S_PIV_RD;
                    end
                    else
                    begin
                        cell_next  = cell_reg + 1'b1;
                        state_next = S_RED_RD;
                    end
                end
            end
            S_PIV_RD: state_next = S_PIV_CHK;
            S_PIV_CHK:
            begin
                if (!sts.rd_zero)
                begin
                    if (piv_reg == col_reg)
                    begin
                        state_next = S_PV_RD;
                    end
                    else
                    begin
                        k_next     = col_reg;
                        state_next = S_SWP_RD0;
                    end
                end
                else if (piv_reg == LAST_IDX)
                begin
                    state_next = S_OUT_SING;
                end
                else
                begin
                    piv_next   = piv_reg + 1'b1;
                    state_next = S_PIV_RD;
                end
            end
            S_SWP_RD0: state_next = S_SWP_RD1;
            S_SWP_RD1: state_next = S_SWP_X;
            S_SWP_X:   state_next = S_SWP_W;
            S_SWP_W:
            begin
                if (k_reg == LAST_IDX)
                begin
                    state_next = S_NEG;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_SWP_RD0;
                end
            end
            S_NEG:    state_next = S_PV_RD;
            S_PV_RD:  state_next = S_PV_MUL;
            S_PV_MUL: state_next = S_PV_WAIT;
            S_PV_WAIT:
            begin
                if (!sts.mul_busy)
                begin
                    if (col_reg == LAST_IDX)
                    begin
                        state_next = S_OUT_DET;
                    end
                    else
                    begin
                        ebit_next  = '0;
                        state_next = S_POW_SQ;
                    end
                end
            end
            S_POW_SQ: state_next = S_POW_SQW;
            S_POW_SQW:
            begin
                if (!sts.mul_busy)
                begin
                    state_next = sts.e_msb ? S_POW_ML : S_POW_NX;
                end
            end
            S_POW_ML: state_next = S_POW_MLW;
            S_POW_MLW:
            begin
                if (!sts.mul_busy)
                begin
                    state_next = S_POW_NX;
                end
            end
            S_POW_NX:
            begin
                if (ebit_reg == LAST_BIT)
                begin
                    row_next   = col_reg + 1'b1;
                    state_next = S_ROW_RD;
                end
                else
                begin
                    ebit_next  = ebit_reg + 1'b1;
                    state_next = S_POW_SQ;
                end
            end
            S_ROW_RD: state_next = S_ROW_CHK;
            S_ROW_CHK,
            S_K_WAIT:
            begin
                if ((state_reg == S_ROW_CHK && !sts.rd_zero) ||
                    (state_reg == S_K_WAIT && sts.mul_busy))
                begin
                    state_next = (state_reg == S_ROW_CHK) ? S_F_WAIT : S_K_WAIT;
                end
                else if (state_reg == S_K_WAIT && k_reg != LAST_IDX)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_K_RD;
                end
                else if (row_reg == LAST_IDX)
                begin
                    col_next   = col_reg + 1'b1;
                    piv_next   = col_reg + 1'b1;
                    state_next = S_PIV_RD;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = S_ROW_RD;
                end
            end
            S_F_WAIT:
            begin
                if (!sts.mul_busy)
                begin
                    k_next     = col_reg;
                    state_next = S_K_RD;
                end
            end
            S_K_RD:     state_next = S_K_MUL;
            S_K_MUL:    state_next = S_K_WAIT;
            S_OUT_DET:  state_next = S_IDLE;
            S_OUT_SING: state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath commands and RAM addresses
    always_comb
    begin
        cmd.op = OP_NONE;
        raddr  = '0;
        waddr  = '0;
        case (state_reg)
            S_IDLE:      cmd.op = start ? OP_MUL_IN : OP_NONE;
            S_LOAD_WAIT:
            begin
                waddr  = cell_reg;
                cmd.op = sts.mul_busy ? OP_NONE : OP_WR_PROD;
            end
            S_RED_RD:
            begin
                raddr  = cell_reg;
                cmd.op = OP_DET_INIT;
            end
            S_RED_MUL:   cmd.op = OP_MUL_RED;
            S_RED_WAIT:
            begin
                waddr  = cell_reg;
                cmd.op = sts.mul_busy ? OP_NONE : OP_WR_PROD;
            end
            S_PIV_RD,
            S_PIV_CHK:   raddr = cell_addr(piv_reg, col_reg);
            S_SWP_RD0:   raddr = cell_addr(piv_reg, k_reg);
            S_SWP_RD1:
            begin
                raddr  = cell_addr(col_reg, k_reg);
                cmd.op = OP_TMP_RD;
            end
            S_SWP_X:
            begin
                waddr  = cell_addr(col_reg, k_reg);
                cmd.op = OP_XCH;
            end
            S_SWP_W:
            begin
                waddr  = cell_addr(piv_reg, k_reg);
                cmd.op = OP_WR_TMP;
            end
            S_NEG:       cmd.op = OP_NEG_DET;
            S_PV_RD:     raddr = cell_addr(col_reg, col_reg);
            S_PV_MUL:
            begin
                raddr  = cell_addr(col_reg, col_reg);
                cmd.op = OP_PIVOT;
            end
            S_PV_WAIT:   cmd.op = sts.mul_busy ? OP_NONE : OP_DET_PROD;
            S_POW_SQ:    cmd.op = OP_MUL_SQ;
            S_POW_SQW:   cmd.op = sts.mul_busy ? OP_NONE : OP_INV_PROD;
            S_POW_ML:    cmd.op = OP_MUL_BASE;
            S_POW_MLW:   cmd.op = sts.mul_busy ? OP_NONE : OP_INV_PROD;
            S_POW_NX:    cmd.op = OP_E_SHIFT;
            S_ROW_RD:    raddr = cell_addr(row_reg, col_reg);
            S_ROW_CHK:
            begin
                raddr  = cell_addr(row_reg, col_reg);
                cmd.op = sts.rd_zero ? OP_NONE : OP_MUL_F;
            end
            S_F_WAIT:    cmd.op = sts.mul_busy ? OP_NONE : OP_F_PROD;
            S_K_RD:      raddr = cell_addr(col_reg, k_reg);
            S_K_MUL:
            begin
                raddr  = cell_addr(col_reg, k_reg);
                cmd.op = OP_MUL_FP;
            end
            S_K_WAIT:
            begin
                raddr  = cell_addr(row_reg, k_reg);
                waddr  = cell_addr(row_reg, k_reg);
                cmd.op = sts.mul_busy ? OP_NONE : OP_WR_SUB;
            end
            S_OUT_DET:   cmd.op = OP_OUT_DET;
            S_OUT_SING:  cmd.op = OP_OUT_SING;
            default:     cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cell_reg  <= '0;
            col_reg   <= '0;
            piv_reg   <= '0;
            row_reg   <= '0;
            k_reg     <= '0;
            ebit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cell_reg  <= cell_next;
            col_reg   <= col_next;
            piv_reg   <= piv_next;
            row_reg   <= row_next;
            k_reg     <= k_next;
            ebit_reg  <= ebit_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `DMG_ASSERT_NXT(a_accept_load, clk, rst_n, start && state_reg == S_IDLE,
                    state_reg == S_LOAD_WAIT)
    `DMG_ASSERT_IMP(a_wr_after_mul, clk, rst_n,
                    cmd.op == OP_WR_PROD || cmd.op == OP_WR_SUB, !sts.mul_busy)
    `DMG_ASSERT_IMP(a_cell_range, clk, rst_n, 1'b1, cell_reg <= LAST_CELL)

endmodule

### sv/modular_determinant_gauss.sv
// Top level of the modular determinant block: APB register and the
// controller/datapath pair. Depends on dmg_pkg, dmg_ctrl and dmg_dp.
//
// Send the DIM*DIM matrix entries in row-major order, one request per
// start pulse while busy is low. Each entry is reduced modulo the modulus
// register on a bit-serial modular multiplier, and busy stays high until
// that product is written. After the last entry the block reduces the
// stored entries again, then eliminates column by column on the same
// multiplier, with a Fermat inverse of up to 64 modular products per
// pivot. The result appears for exactly one cycle with done high and
// cannot be held off, so the receiver must capture it then.
module modular_determinant_gauss
    import dmg_pkg::*;
#(
    parameter int DIM = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]  pwdata,
    output logic [WORD_W-1:0]  prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [WORD_W-1:0]  entry,
    output logic               done,
    output logic [WORD_W-1:0]  det_value,
    output logic               is_singular
);

    localparam int AW = $clog2(DIM * DIM);

    logic [WORD_W-1:0] modulus_reg, modulus_next;
    logic [WORD_W-1:0] m_eff;
    logic [AW-1:0]     raddr, waddr;
    cmd_t              cmd;
    sts_t              sts;

    // register write on the access phase
    always_comb
    begin
        modulus_next = modulus_reg;
        if (psel && penable && pwrite && paddr == ADDR_MODULUS)
        begin
            modulus_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MODULUS) ? modulus_reg : '0;

    // moduli 0 and 1 act as 1
    assign m_eff = (modulus_reg < WORD_W'(2)) ? WORD_W'(1) : modulus_reg;

    dmg_ctrl #(.DIM(DIM)) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd),
        .raddr (raddr),
        .waddr (waddr)
    );

    dmg_dp #(.DIM(DIM)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (entry),
        .m_eff       (m_eff),
        .cmd         (cmd),
        .raddr       (raddr),
        .waddr       (waddr),
        .sts         (sts),
        .done        (done),
        .det_value   (det_value),
        .is_singular (is_singular)
    );

endmodule
